/* rtl/core/tks_pkg.sv */
// Shared constants and types of the top-K smallest selector.
package tks_pkg;

  localparam int MAX_KEEP   = 32;
  localparam int POS_W      = 32;
  localparam int DIST_W     = 64;
  localparam int INDEX_W    = 32;
  localparam int RANK_W     = 5;
  localparam int KEEP_W     = 6;
  localparam int KEEP_RESET = 8;

  // Heap slot address and fill count widths.
  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  typedef struct packed {
    logic [DIST_W-1:0] value;
    logic [POS_W-1:0]  pos;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

endpackage

/* rtl/core/tks_if.sv */
// Valid/ready channel interfaces for elements in and ranked results out.
interface tks_in_if;
  import tks_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              last_in_row;

  modport source (output valid, distance, last_in_row, input ready);
  modport sink   (input valid, distance, last_in_row, output ready);
endinterface

interface tks_out_if;
  import tks_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  best_distance;
  logic [INDEX_W-1:0] best_index;
  logic [RANK_W-1:0]  rank;
  logic               last_result;

  modport source (output valid, best_distance, best_index, rank, last_result, input ready);
  modport sink   (input valid, best_distance, best_index, rank, last_result, output ready);
endinterface

/* rtl/core/tks_heap_ram.sv */
// Heap storage: one write port, two read ports with registered read data.
module tks_heap_ram (
  input  logic                  clk,
  input  tks_pkg::ram_wr_t      wr,
  input  logic [tks_pkg::IDX_W-1:0] raddr_a,
  input  logic [tks_pkg::IDX_W-1:0] raddr_b,
  output tks_pkg::entry_t       rdata_a,
  output tks_pkg::entry_t       rdata_b
);
  import tks_pkg::*;

  entry_t mem [MAX_KEEP];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/core/top_k_smallest_selector.sv */
// Top-K smallest selector: a max-heap over one row, heap-sorted out at the row's end.
//
// Elements of a row arrive one per request and are numbered from zero; the K
// smallest (K = keep_count, 0 read as 1, saturated at MAX_KEEP, latched at a
// row's first element) are kept with their positions in a max-heap held in a
// two-read, one-write RAM. One compare unit serves every sift-down; each level
// moved is a RAM read, then a compare and write. An element that only fills a
// slot is written straight in; a later element is compared with the root and,
// when smaller, replaces it and sifts down. The element that fills the heap,
// or a row's last element when it still fills a slot, also runs the bottom-up
// build, which loads and sifts down each inner node. On the last element the
// heap is sorted in place and the kept pairs leave in ascending order, each
// held until downstream takes it. The block takes no element during this work.
module top_k_smallest_selector (
  input  logic                        clk,
  input  logic                        rst_n,
  tks_in_if.sink                      in_ch,
  tks_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [tks_pkg::KEEP_W-1:0]  cfg_wdata
);
  import tks_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT_CMP, S_BUILD_NEXT, S_BUILD_LD, S_SINK_RD, S_SINK_CMP,
    S_SORT_RD, S_SORT_SWAP, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
  } state_t;

  typedef enum logic [1:0] {PH_INS, PH_BUILD, PH_SORT} phase_t;

  localparam int CW = IDX_W + 2;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [KEEP_W-1:0]   keep_cfg_r, keep_cfg_nxt;
  logic [CNT_W-1:0]    keep_act_r, keep_act_nxt;
  logic                row_open_r, row_open_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [POS_W-1:0]    rowpos_r, rowpos_nxt;
  logic                last_r, last_nxt;
  entry_t              din_r, din_nxt;
  entry_t              cur_r, cur_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [IDX_W-1:0]    bi_r, bi_nxt;
  logic [IDX_W-1:0]    si_r, si_nxt;
  logic [IDX_W-1:0]    ek_r, ek_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [RANK_W-1:0]   out_rank_r, out_rank_nxt;
  logic                out_last_r, out_last_nxt;

  ram_wr_t             wr;
  logic [IDX_W-1:0]    raddr_a, raddr_b;
  entry_t              rdata_a, rdata_b;

  logic                accept;
  logic [CNT_W-1:0]    keep_eff, k_use, fill_use, fill_inc;
  logic [IDX_W-1:0]    base;
  logic [CW-1:0]       lc, rc;
  logic                l_ok, r_ok, gl, take_r;
  state_t              sort_first;
  logic [IDX_W-1:0]    si_init;

  tks_heap_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign accept               = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.best_distance = out_dist_r;
  assign out_ch.best_index    = out_index_r;
  assign out_ch.rank          = out_rank_r;
  assign out_ch.last_result   = out_last_r;

  always_comb begin
    if (keep_cfg_r == '0) begin
      keep_eff = CNT_W'(1);
    end else if (32'(keep_cfg_r) > 32'(MAX_KEEP)) begin
      keep_eff = CNT_W'(MAX_KEEP);
    end else begin
      keep_eff = CNT_W'(keep_cfg_r);
    end
  end

  assign k_use    = row_open_r ? keep_act_r : keep_eff;
  assign fill_use = row_open_r ? fill_r : '0;
  assign fill_inc = fill_use + CNT_W'(1);

  // Children of the sinking slot; the root when a sift starts from the top.
  assign base = (state_r == S_SORT_SWAP || state_r == S_ROOT_CMP) ? '0 : i_r;
  assign lc   = {1'b0, base, 1'b1};
  assign rc   = lc + CW'(1);
  assign l_ok = lc < CW'(n_r);
  assign r_ok = rc < CW'(n_r);
  assign gl   = l_ok && (rdata_a.value > cur_r.value);
  // Right child wins only when strictly larger than the current biggest.
  assign take_r = r_ok && (gl ? (rdata_b.value > rdata_a.value)
                              : (rdata_b.value > cur_r.value));

  assign sort_first = (fill_r > CNT_W'(1)) ? S_SORT_RD : S_EMIT_RD;
  assign si_init    = IDX_W'(fill_r - CNT_W'(1));

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    unique case (state_r)
      S_BUILD_NEXT: raddr_a = bi_r - IDX_W'(1);
      S_SORT_RD:    raddr_b = si_r;
      S_EMIT_RD:    raddr_a = ek_r;
      S_SINK_RD, S_BUILD_LD, S_SORT_SWAP, S_ROOT_CMP: begin
        raddr_a = lc[IDX_W-1:0];
        raddr_b = rc[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    keep_cfg_nxt  = cfg_we ? cfg_wdata : keep_cfg_r;
    keep_act_nxt  = keep_act_r;
    row_open_nxt  = row_open_r;
    fill_nxt      = fill_r;
    rowpos_nxt    = rowpos_r;
    last_nxt      = last_r;
    din_nxt       = din_r;
    cur_nxt       = cur_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    bi_nxt        = bi_r;
    si_nxt        = si_r;
    ek_nxt        = ek_r;
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;
    out_index_nxt = out_index_r;
    out_rank_nxt  = out_rank_r;
    out_last_nxt  = out_last_r;
    wr            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          keep_act_nxt  = k_use;
          row_open_nxt  = 1'b1;
          rowpos_nxt    = rowpos_r + POS_W'(1);
          last_nxt      = in_ch.last_in_row;
          din_nxt.value = in_ch.distance;
          din_nxt.pos   = rowpos_r;
          if (fill_use < k_use) begin
            wr.en      = 1'b1;
            wr.addr    = fill_use[IDX_W-1:0];
            wr.data    = {in_ch.distance, rowpos_r};
            fill_nxt   = fill_inc;
            // Build once the heap is full, or early on a short row's end.
            if (fill_inc == k_use || in_ch.last_in_row) begin
              n_nxt     = fill_inc;
              bi_nxt    = IDX_W'(fill_inc >> 1);
              phase_nxt = PH_BUILD;
              state_nxt = S_BUILD_NEXT;
            end else begin
              fill_nxt  = fill_inc;
            end
          end else begin
            fill_nxt  = fill_use;
            state_nxt = S_ROOT_CMP;
          end
        end
      end

      S_ROOT_CMP: begin
        if (din_r.value < rdata_a.value) begin
          cur_nxt   = din_r;
          i_nxt     = '0;
          n_nxt     = fill_r;
          phase_nxt = PH_INS;
          state_nxt = S_SINK_CMP;
        end else if (last_r) begin
          si_nxt    = si_init;
          state_nxt = sort_first;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_BUILD_NEXT: begin
        if (bi_r == '0) begin
          if (last_r) begin
            si_nxt    = si_init;
            state_nxt = sort_first;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          bi_nxt    = bi_r - IDX_W'(1);
          i_nxt     = bi_r - IDX_W'(1);
          state_nxt = S_BUILD_LD;
        end
      end

      S_BUILD_LD: begin
        cur_nxt   = rdata_a;
        state_nxt = S_SINK_CMP;
      end

      S_SINK_RD: begin
        state_nxt = S_SINK_CMP;
      end

      S_SINK_CMP: begin
        wr.en   = 1'b1;
        wr.addr = i_r;
        if (take_r) begin
          wr.data   = rdata_b;
          i_nxt     = rc[IDX_W-1:0];
          state_nxt = S_SINK_RD;
        end else if (gl) begin
          wr.data   = rdata_a;
          i_nxt     = lc[IDX_W-1:0];
          state_nxt = S_SINK_RD;
        end else begin
          // Settle the sinking entry and return to the caller.
          wr.data = cur_r;
          unique case (phase_r)
            PH_INS: begin
              if (last_r) begin
                si_nxt    = si_init;
                state_nxt = sort_first;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            PH_BUILD: state_nxt = S_BUILD_NEXT;
            PH_SORT: begin
              if (si_r == IDX_W'(1)) begin
                state_nxt = S_EMIT_RD;
              end else begin
                si_nxt    = si_r - IDX_W'(1);
                state_nxt = S_SORT_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_SORT_RD: begin
        state_nxt = S_SORT_SWAP;
      end

      S_SORT_SWAP: begin
        // Move the root to the tail; sift the old tail entry from the top.
        wr.en     = 1'b1;
        wr.addr   = si_r;
        wr.data   = rdata_a;
        cur_nxt   = rdata_b;
        i_nxt     = '0;
        n_nxt     = CNT_W'(si_r);
        phase_nxt = PH_SORT;
        state_nxt = S_SINK_CMP;
      end

      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_dist_nxt  = rdata_a.value;
        out_index_nxt = INDEX_W'(rdata_a.pos);
        out_rank_nxt  = RANK_W'(ek_r);
        out_last_nxt  = (CNT_W'(ek_r) + CNT_W'(1)) == fill_r;
        state_nxt     = S_EMIT_WAIT;
      end

      S_EMIT_WAIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt     = '0;
            rowpos_nxt   = '0;
            row_open_nxt = 1'b0;
            ek_nxt       = '0;
            state_nxt    = S_IDLE;
          end else begin
            ek_nxt    = ek_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    phase_r     <= phase_nxt;
    last_r      <= last_nxt;
    din_r       <= din_nxt;
    cur_r       <= cur_nxt;
    i_r         <= i_nxt;
    n_r         <= n_nxt;
    bi_r        <= bi_nxt;
    si_r        <= si_nxt;
    out_dist_r  <= out_dist_nxt;
    out_index_r <= out_index_nxt;
    out_rank_r  <= out_rank_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      keep_cfg_r  <= KEEP_W'(KEEP_RESET);
      keep_act_r  <= CNT_W'(KEEP_RESET);
      row_open_r  <= 1'b0;
      fill_r      <= '0;
      rowpos_r    <= '0;
      ek_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      keep_cfg_r  <= keep_cfg_nxt;
      keep_act_r  <= keep_act_nxt;
      row_open_r  <= row_open_nxt;
      fill_r      <= fill_nxt;
      rowpos_r    <= rowpos_nxt;
      ek_r        <= ek_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("element taken while a result is pending");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_open_r |-> (fill_r <= keep_act_r))
    else $error("heap fill exceeds kept count");

  a_keep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (keep_act_r != '0) && (32'(keep_act_r) <= 32'(MAX_KEEP)))
    else $error("latched keep count out of range");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (CNT_W'(out_ch.rank) < fill_r))
    else $error("rank beyond heap fill");

  a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_result)
      |=> (!row_open_r && fill_r == '0 && rowpos_r == '0))
    else $error("row not closed after final result");
`endif

endmodule
